[sv/ualu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ualu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_INC = 3'd5,
        OP_NA6 = 3'd6,
        OP_NA7 = 3'd7
    } op_t;

endpackage

`default_nettype wire

[sv/unsigned_integer_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

// Unsigned ALU: add, floored subtract, wrapping multiply, divide, modulo and
// increment on DATA_WIDTH-bit operands. A fully pipelined design: one word is
// accepted every cycle while the output word is not stalled, passing through a
// front stage, DATA_WIDTH one-bit multiply/divide steps and an output register.
// The whole pipeline holds while the output word is stalled, so in_stall
// follows out_valid and out_stall. Divide or modulo by zero and unused opcodes
// give zero.
module unsigned_integer_alu #(
    parameter int DATA_WIDTH = ualu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [ualu_pkg::OP_W-1:0] op,
    input  wire logic [DATA_WIDTH-1:0]   operand_a,
    input  wire logic [DATA_WIDTH-1:0]   operand_b,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [DATA_WIDTH-1:0]        result
);
    import ualu_pkg::*;

    localparam int N = DATA_WIDTH;

    logic                vld  [0:N];
    op_t                 opc  [0:N];
    logic [N-1:0]        aa   [0:N];
    logic [N-1:0]        bb   [0:N];
    logic [N:0]          acc  [0:N];
    logic                en;
    logic                out_valid_reg;
    logic [N-1:0]        result_reg, result_next;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    ualu_front #(.WIDTH(N)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .vld_in(in_valid), .op_in(op_t'(op)), .a_in(operand_a), .b_in(operand_b),
        .vld_out(vld[0]), .op_out(opc[0]), .a_out(aa[0]), .b_out(bb[0]),
        .acc_out(acc[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_step
        ualu_step #(.WIDTH(N), .STEP(i)) u_step (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vld_in(vld[i]), .op_in(opc[i]), .a_in(aa[i]), .b_in(bb[i]),
            .acc_in(acc[i]),
            .vld_out(vld[i+1]), .op_out(opc[i+1]), .a_out(aa[i+1]),
            .b_out(bb[i+1]), .acc_out(acc[i+1])
        );
    end

    always_comb
    begin
        unique case (opc[N])
            OP_DIV:  result_next = (bb[N] == '0) ? '0 : aa[N];
            OP_MOD:  result_next = (bb[N] == '0) ? '0 : acc[N][N-1:0];
            default: result_next = acc[N][N-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output word");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld[N] && (opc[N] == OP_DIV || opc[N] == OP_MOD) && bb[N] == '0)
        |=> (result == '0))
        else $error("division by zero gave a non-zero result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (out_valid && $stable(result)))
        else $error("output word changed while held");

endmodule

`default_nettype wire

[sv/ualu_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ualu_front #(
    parameter int WIDTH = ualu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               vld_in,
    input  wire ualu_pkg::op_t      op_in,
    input  wire logic [WIDTH-1:0]   a_in,
    input  wire logic [WIDTH-1:0]   b_in,
    output logic                    vld_out,
    output ualu_pkg::op_t           op_out,
    output logic [WIDTH-1:0]        a_out,
    output logic [WIDTH-1:0]        b_out,
    output logic [WIDTH:0]          acc_out
);
    import ualu_pkg::*;

    logic             vld_reg;
    op_t              op_reg;
    logic [WIDTH-1:0] a_reg, b_reg;
    logic [WIDTH:0]   acc_reg, acc_next;
    logic [WIDTH:0]   diff;

    // simple operations finish here; the step chain carries them through
    always_comb
    begin
        diff = {1'b0, a_in} - {1'b0, b_in};
        unique case (op_in)
            OP_ADD:  acc_next = {1'b0, a_in + b_in};
            OP_SUB:  acc_next = diff[WIDTH] ? '0 : {1'b0, diff[WIDTH-1:0]};
            OP_INC:  acc_next = {1'b0, a_in + {{(WIDTH-1){1'b0}}, 1'b1}};
            default: acc_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg  <= op_in;
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= acc_next;
        end
    end

    assign vld_out = vld_reg;
    assign op_out  = op_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign acc_out = acc_reg;

endmodule

`default_nettype wire

[sv/ualu_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module ualu_step #(
    parameter int WIDTH = ualu_pkg::DATA_WIDTH_DEF,
    parameter int STEP  = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               vld_in,
    input  wire ualu_pkg::op_t      op_in,
    input  wire logic [WIDTH-1:0]   a_in,
    input  wire logic [WIDTH-1:0]   b_in,
    input  wire logic [WIDTH:0]     acc_in,
    output logic                    vld_out,
    output ualu_pkg::op_t           op_out,
    output logic [WIDTH-1:0]        a_out,
    output logic [WIDTH-1:0]        b_out,
    output logic [WIDTH:0]          acc_out
);
    import ualu_pkg::*;

    localparam int BIT = WIDTH - 1 - STEP;

    logic             vld_reg;
    op_t              op_reg;
    logic [WIDTH-1:0] a_reg, b_reg, a_next;
    logic [WIDTH:0]   acc_reg, acc_next;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   rem_sub;
    logic             ge;
    logic [WIDTH-1:0] addend;

    // one restoring divide bit or one shift-add multiply bit, msb first
    always_comb
    begin
        rem_sh  = {acc_in[WIDTH-1:0], a_in[WIDTH-1]};
        rem_sub = rem_sh - {1'b0, b_in};
        ge      = (rem_sh >= {1'b0, b_in});
        addend  = b_in[BIT] ? a_in : '0;
        a_next  = a_in;
        acc_next = acc_in;
        unique case (op_in)
            OP_MUL:
                acc_next = {1'b0, {acc_in[WIDTH-2:0], 1'b0} + addend};
            OP_DIV, OP_MOD:
            begin
                a_next   = {a_in[WIDTH-2:0], ge};
                acc_next = ge ? rem_sub : rem_sh;
            end
            default:
                acc_next = acc_in;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg  <= op_in;
            a_reg   <= a_next;
            b_reg   <= b_in;
            acc_reg <= acc_next;
        end
    end

    assign vld_out = vld_reg;
    assign op_out  = op_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign acc_out = acc_reg;

endmodule

`default_nettype wire

[tb/sv/unsigned_integer_alu_checker.sv]
`timescale 1ns / 1ps

module unsigned_integer_alu_checker
    import ualu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic [DATA_WIDTH-1:0] operand_a,
    input  wire logic [DATA_WIDTH-1:0] operand_b,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [DATA_WIDTH-1:0] result,
    output int                         fail_count,
    output int                         pending_count
);

    logic [DATA_WIDTH-1:0] result_q[$];
    int                    mismatch_count = 0;

    function automatic logic [DATA_WIDTH-1:0] alu_result(op_t code,
                                                         logic [DATA_WIDTH-1:0] a,
                                                         logic [DATA_WIDTH-1:0] b);
        case (code)
            OP_ADD: return a + b;
            OP_SUB: return (a < b) ? '0 : a - b;
            OP_MUL: return a * b;
            OP_DIV: return (b == 0) ? '0 : a / b;
            OP_MOD: return (b == 0) ? '0 : a % b;
            OP_INC: return a + 1'b1;
            default: return '0;
        endcase
    endfunction

    assign fail_count    = mismatch_count;
    assign pending_count = result_q.size();

    always @(posedge clk)
    begin
        logic [DATA_WIDTH-1:0] want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                result_q.push_back(alu_result(op_t'(op), operand_a, operand_b));
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result word %h", result);
                    mismatch_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want !== result)
                    begin
                        if (mismatch_count < 10)
                            $display("result mismatch: expected %h actual %h", want, result);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/unsigned_integer_alu_tb.sv]
`timescale 1ns / 1ps

module unsigned_integer_alu_tb;
    import ualu_pkg::*;

    localparam int DW        = 32;
    localparam int IDLE_LIMIT = 20000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [OP_W-1:0] op = '0;
    logic [DW-1:0] operand_a = '0;
    logic [DW-1:0] operand_b = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [DW-1:0] result;
    int            fail_count;
    int            pending_count;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    bit            hold_off = 1'b0;
    int            quiet_cycles = 0;

    always #10 clk = ~clk;

    unsigned_integer_alu #(.DATA_WIDTH(DW)) u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_stall(out_stall), .result(result)
    );

    unsigned_integer_alu_checker #(.DATA_WIDTH(DW)) u_chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_stall(out_stall), .result(result),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // receiver stall, random or held for a long stretch
    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[unsigned_integer_alu] ERROR");
            $finish;
        end
    end

    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return DW'($urandom_range(15));
            3: return DW'($urandom) | {1'b1, {(DW-1){1'b0}}};
            default: return DW'($urandom);
        endcase
    endfunction

    // offer one word and hold it until taken
    task automatic send_word(logic [OP_W-1:0] code, logic [DW-1:0] a, logic [DW-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic random_words(int n);
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        for (int i = 0; i < n; i++)
        begin
            a = pick_operand();
            b = pick_operand();
            if ($urandom_range(9) == 0)
                b = a;
            send_word(OP_W'($urandom_range(7)), a, b);
        end
    endtask

    initial
    begin
        logic [DW-1:0] ones;
        ones = '1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes and corner cases
        send_word(OP_ADD, ones, 1);
        send_word(OP_ADD, 0, 0);
        send_word(OP_SUB, 3, 5);
        send_word(OP_SUB, ones, ones);
        send_word(OP_SUB, ones, 0);
        send_word(OP_MUL, ones, ones);
        send_word(OP_MUL, 32'h0001_0000, 32'h0001_0000);
        send_word(OP_DIV, ones, 0);
        send_word(OP_DIV, ones, 1);
        send_word(OP_DIV, 7, ones);
        send_word(OP_DIV, ones, ones);
        send_word(OP_MOD, ones, 0);
        send_word(OP_MOD, ones, 10);
        send_word(OP_MOD, 0, 3);
        send_word(OP_INC, ones, ones);
        send_word(OP_INC, 0, 123);
        send_word(OP_NA6, ones, ones);
        send_word(OP_NA7, 5, 3);
        // sender pause until all results are back
        drain();

        random_words(250);
        send_idle_pct = 51;
        random_words(170);
        send_idle_pct = 0;
        stall_pct = 51;
        random_words(170);
        send_idle_pct = 11;
        stall_pct = 11;
        random_words(170);

        // long receiver hold-off while the sender keeps offering words
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            random_words(100);
        join
        send_idle_pct = 0;
        stall_pct = 0;
        random_words(80);

        drain();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("[unsigned_integer_alu] OK");
        else
            $display("[unsigned_integer_alu] ERROR");
        $finish;
    end

endmodule
